// ===== src/pcj_pkg.sv =====
// ----------------------------------------------------------------------------
// pcj_pkg
// shared types and constants for the poisson cell jacobi update block
// ----------------------------------------------------------------------------
package pcj_pkg;

	localparam int FACES_PER_CELL = 4;
	localparam int FACE_CNT_W     = $clog2(FACES_PER_CELL);
	localparam int DIV_W          = 64;
	localparam int DIVISOR_W      = 48;
	localparam int DIV_CNT_W      = $clog2(DIV_W);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DOT,
		ST_DIV,
		ST_MUL_HI,
		ST_MUL_LO,
		ST_COEF,
		ST_TERM,
		ST_ACC,
		ST_FIN,
		ST_QDIV,
		ST_OUT
	} pcj_state_t;

	typedef struct packed {
		logic load_in;
		logic dot;
		logic div_start;
		logic div_final;
		logic mul_hi;
		logic mul_lo;
		logic coef;
		logic coef_zero;
		logic term;
		logic acc;
		logic load_out;
	} pcj_cmd_t;

	typedef struct packed {
		logic dist_zero;
		logic div_busy;
		logic div_done;
		logic last_face;
		logic final_fault;
		logic out_free;
	} pcj_status_t;

endpackage

// ===== src/poisson_cell_jacobi_update.sv =====
// ----------------------------------------------------------------------------
// poisson_cell_jacobi_update
// jacobi point update of a finite-volume poisson cell, one face per transfer
// ----------------------------------------------------------------------------
// Usage: each input transfer carries one face (normal, center vector, center
// distance, area, neighbor value). After every FACES_PER_CELL-th face the
// block offers one result: weighted sum over coefficient sum in Q16.16,
// saturated, with divide_fault set (and value zero) on a zero distance or a
// zero coefficient sum. Other faces give no result.
// Steps: a face with a nonzero distance goes from its transfer to the next
// possible transfer through accept, dot product, the shared bit-serial
// divider (start, 64 quotient bits, done), a multiply of bits 47:16 and one
// of bits 15:0 of the quotient by the area, coefficient clamp, weight
// multiply and accumulate. A zero-distance face skips the divider, the
// multiplies and the clamp. The last face of a cell adds a setup step, the
// final quotient through the same divider (none on a fault) and an output load.
// in_ready is high only while no face is in flight.
// Reset clears the accumulators, face count, output valid, divider and sequencer.
// A stalled receiver holds the result register; a face may still be taken
// meanwhile, and a next cell result waits until the register is taken.
// ----------------------------------------------------------------------------
module poisson_cell_jacobi_update
	import pcj_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [31:0] center_vec_x,
	input  logic signed [31:0] center_vec_y,
	input  logic        [31:0] center_distance,
	input  logic        [31:0] face_area,
	input  logic signed [31:0] neighbor_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] new_value,
	output logic               divide_fault
);

	pcj_cmd_t    cmd;
	pcj_status_t st;

	pcj_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	pcj_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.normal_x        (normal_x),
		.normal_y        (normal_y),
		.center_vec_x    (center_vec_x),
		.center_vec_y    (center_vec_y),
		.center_distance (center_distance),
		.face_area       (face_area),
		.neighbor_value  (neighbor_value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.new_value       (new_value),
		.divide_fault    (divide_fault)
	);

endmodule

// ===== src/pcj_div.sv =====
// ----------------------------------------------------------------------------
// pcj_div
// restoring divider, one quotient bit per cycle, unsigned operands
// ----------------------------------------------------------------------------
module pcj_div
	import pcj_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_W-1:0]     dividend,
	input  logic [DIVISOR_W-1:0] divisor,
	output logic                 busy,
	output logic                 done,
	output logic [DIV_W-1:0]     quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIVISOR_W:0]   rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIVISOR_W-1:0] dsr_q;
	logic [DIVISOR_W:0]   trial;
	logic                 take;

	assign trial = {rem_q[DIVISOR_W-1:0], quo_q[DIV_W-1]};
	assign take  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CNT_W'(DIV_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? (trial - {1'b0, dsr_q}) : trial;
			quo_q <= {quo_q[DIV_W-2:0], take};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== src/pcj_datapath.sv =====
// ----------------------------------------------------------------------------
// pcj_datapath
// face coefficient arithmetic, cell accumulators and output register
// ----------------------------------------------------------------------------
module pcj_datapath
	import pcj_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  pcj_cmd_t           cmd,
	output pcj_status_t        st,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [31:0] center_vec_x,
	input  logic signed [31:0] center_vec_y,
	input  logic        [31:0] center_distance,
	input  logic        [31:0] face_area,
	input  logic signed [31:0] neighbor_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] new_value,
	output logic               divide_fault
);

	logic signed [15:0] nx_q, ny_q;
	logic signed [31:0] dx_q, dy_q, nb_q;
	logic        [31:0] dist_q, area_q;

	logic signed [48:0] dot_q;
	logic        [63:0] prod_hi_q;
	logic        [47:0] prod_lo_q;
	logic               big_q;
	logic signed [31:0] coef_q;
	logic signed [63:0] term_q;

	logic [FACE_CNT_W-1:0] face_cnt_q;
	logic signed [47:0]    csum_q;
	logic signed [63:0]    wsum_q;
	logic                  fault_q;

	logic               out_valid_q;
	logic signed [31:0] new_value_q;
	logic               divide_fault_q;

	logic [47:0]          dot_mag;
	logic [DIV_W-1:0]     div_a;
	logic [DIVISOR_W-1:0] div_b;
	logic                 div_busy, div_done;
	logic [DIV_W-1:0]     div_q;
	logic [64:0]          m;
	logic                 m_sat;
	logic signed [63:0]   wsum_add;
	logic                 wsum_ovf;
	logic [63:0]          wsum_mag;
	logic [47:0]          csum_mag;
	logic                 fin_neg;
	logic signed [31:0]   fin_val;
	logic                 fin_fault;

	assign dot_mag  = dot_q[48] ? 48'(-dot_q) : dot_q[47:0];
	assign wsum_mag = wsum_q[63] ? 64'(-wsum_q) : 64'(wsum_q);
	assign csum_mag = csum_q[47] ? 48'(-csum_q) : 48'(csum_q);

	assign div_a = cmd.div_final ? wsum_mag : {14'b0, dot_mag, 2'b00};
	assign div_b = cmd.div_final ? csum_mag : {16'b0, dist_q};

	pcj_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	// floor(q * area / 2^16) split into bits 47:16 and bits 15:0 of q
	assign m     = {1'b0, prod_hi_q} + {33'b0, prod_lo_q[47:16]};
	assign m_sat = big_q || (m[64:32] != '0);

	assign wsum_add = wsum_q + term_q;
	assign wsum_ovf = (wsum_q[63] == term_q[63]) && (wsum_add[63] != wsum_q[63]);

	assign fin_fault = fault_q || (csum_q == '0);
	assign fin_neg   = wsum_q[63] ^ csum_q[47];

	always_comb begin
		if (fin_neg)
			fin_val = (div_q > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-div_q);
		else
			fin_val = (div_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(div_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			nx_q   <= normal_x;
			ny_q   <= normal_y;
			dx_q   <= center_vec_x;
			dy_q   <= center_vec_y;
			dist_q <= center_distance;
			area_q <= face_area;
			nb_q   <= neighbor_value;
		end
		if (cmd.dot)
			dot_q <= 49'(nx_q * dx_q) + 49'(ny_q * dy_q);
		if (cmd.mul_hi) begin
			prod_hi_q <= 64'(div_q[47:16]) * 64'(area_q);
			big_q     <= (div_q[63:48] != '0) && (area_q != '0);
		end
		if (cmd.mul_lo)
			prod_lo_q <= 48'(div_q[15:0]) * 48'(area_q);
		if (cmd.coef_zero) begin
			coef_q <= '0;
		end else if (cmd.coef) begin
			if (dot_q[48])
				coef_q <= (m_sat || m[31:0] > 32'h8000_0000) ? 32'sh8000_0000
					: 32'(-m[31:0]);
			else
				coef_q <= (m_sat || m[31:0] > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF
					: 32'(m[31:0]);
		end
		if (cmd.term)
			term_q <= coef_q * nb_q;
		if (cmd.load_out) begin
			new_value_q    <= fin_fault ? '0 : fin_val;
			divide_fault_q <= fin_fault;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_cnt_q  <= '0;
			csum_q      <= '0;
			wsum_q      <= '0;
			fault_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.coef_zero)
				fault_q <= 1'b1;
			if (cmd.acc) begin
				csum_q     <= csum_q + 48'(coef_q);
				face_cnt_q <= face_cnt_q + 1'b1;
				if (wsum_ovf)
					wsum_q <= term_q[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
				else
					wsum_q <= wsum_add;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
				face_cnt_q  <= '0;
				csum_q      <= '0;
				wsum_q      <= '0;
				fault_q     <= 1'b0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign st.dist_zero   = (dist_q == '0);
	assign st.div_busy    = div_busy;
	assign st.div_done    = div_done;
	assign st.last_face   = (face_cnt_q == FACE_CNT_W'(FACES_PER_CELL - 1));
	assign st.final_fault = fin_fault;
	assign st.out_free    = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign new_value    = new_value_q;
	assign divide_fault = divide_fault_q;

endmodule

// ===== src/pcj_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcj_ctrl
// sequencer for the face and cell steps
// ----------------------------------------------------------------------------
module pcj_ctrl
	import pcj_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  pcj_status_t st,
	output pcj_cmd_t    cmd
);

	pcj_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_DOT;
			ST_DOT:    state_d = st.dist_zero ? ST_TERM : ST_DIV;
			ST_DIV:    if (st.div_done) state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_MUL_LO;
			ST_MUL_LO: state_d = ST_COEF;
			ST_COEF:   state_d = ST_TERM;
			ST_TERM:   state_d = ST_ACC;
			ST_ACC:    state_d = st.last_face ? ST_FIN : ST_IDLE;
			ST_FIN:    state_d = st.final_fault ? ST_OUT : ST_QDIV;
			ST_QDIV:   if (st.div_done) state_d = ST_OUT;
			ST_OUT:    if (st.out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_DOT: begin
				cmd.dot       = 1'b1;
				cmd.coef_zero = st.dist_zero;
			end
			// divider is idle only in the first cycle of this step
			ST_DIV:    cmd.div_start = !st.div_busy && !st.div_done;
			ST_MUL_HI: cmd.mul_hi = 1'b1;
			ST_MUL_LO: cmd.mul_lo = 1'b1;
			ST_COEF:   cmd.coef = 1'b1;
			ST_TERM:   cmd.term = 1'b1;
			ST_ACC:    cmd.acc = 1'b1;
			ST_FIN: begin
				cmd.div_final = 1'b1;
				cmd.div_start = !st.final_fault;
			end
			ST_QDIV:   cmd.div_final = 1'b1;
			ST_OUT:    cmd.load_out = st.out_free;
			default:   cmd = '0;
		endcase
	end

	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !st.div_busy)
		else $error("divider busy while idle");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		st.div_done |-> (state_q == ST_DIV || state_q == ST_QDIV))
		else $error("divider result outside a divide step");

	a_out_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> (state_q == ST_IDLE))
		else $error("result load did not end the cell");

endmodule
